// ===== rtl/core/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants, types and saturation helpers for the point projection
// pipeline.
// ----------------------------------------------------------------------------
package cpp_pkg;

    // Register map
    localparam logic [3:0] REG_ROW0_LO    = 4'd0;
    localparam logic [3:0] REG_ROW0_HI    = 4'd1;
    localparam logic [3:0] REG_ROW1_LO    = 4'd2;
    localparam logic [3:0] REG_ROW1_HI    = 4'd3;
    localparam logic [3:0] REG_ROW2_LO    = 4'd4;
    localparam logic [3:0] REG_ROW2_HI    = 4'd5;
    localparam logic [3:0] REG_INTRINSICS = 4'd6;
    localparam logic [3:0] REG_RADIAL     = 4'd7;

    // Reset values: identity transform, no intrinsics, no distortion
    localparam logic [63:0] RST_ROW0_LO = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW1_LO = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_HI = 64'h0000_0000_0001_0000;

    // Quotient bits resolved by the divider, one per stage
    localparam int QBITS = 32;

    // Transform rows: lo/hi register pairs, row 0 first
    typedef logic [5:0][63:0] t_xform;

    // Saturate a sign-extended value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] res;
        if (!v[66] && (|v[65:31])) begin
            res = 32'sh7FFF_FFFF;
        end else if (v[66] && !(&v[65:31])) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Saturate an unsigned 64-bit value shifted down by 16 to 32 bits
    function automatic logic [31:0] usat_q16(input logic [63:0] v);
        logic [31:0] res;
        if (|v[63:48]) begin
            res = 32'hFFFF_FFFF;
        end else begin
            res = v[47:16];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/camera_point_projection.sv =====
// ----------------------------------------------------------------------------
// camera_point_projection
// Pinhole projection of a Q16.16 world point with radial distortion.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_ready        i_point_x/y/z
//   output    out        o_out_valid / i_out_ready      o_pixel_u/v, o_cam_depth,
//                                                       o_depth_invalid
//   config    in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One point per cycle sustained while the output is not stalled; stages: transform (2), divider
// setup, 32 restoring divider stages, sign stage, distortion and intrinsics (8).
// The 32-stage divider is the deepest block. Reset (synchronous, active low)
// clears all valid bits and loads the identity transform. A stall at the
// output freezes the whole pipeline; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module camera_point_projection (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_pixel_u,
    output logic signed [31:0]  o_pixel_v,
    output logic signed [31:0]  o_cam_depth,
    output logic                o_depth_invalid
);
    import cpp_pkg::*;

    t_xform             r_xform;
    logic [63:0]        r_intr;
    logic [62:0]        r_radial;
    logic               en;
    logic               x_vld;
    logic signed [50:0] cam_x;
    logic signed [50:0] cam_y;
    logic signed [50:0] cam_z;
    logic               x_inv;
    logic signed [31:0] x_dep;
    logic               n_vld;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               n_inv;
    logic signed [31:0] n_dep;

    // Advance the pipeline unless the output holds an untaken result
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform[REG_ROW0_LO] <= RST_ROW0_LO;
            r_xform[REG_ROW0_HI] <= '0;
            r_xform[REG_ROW1_LO] <= RST_ROW1_LO;
            r_xform[REG_ROW1_HI] <= '0;
            r_xform[REG_ROW2_LO] <= '0;
            r_xform[REG_ROW2_HI] <= RST_ROW2_HI;
            r_intr               <= '0;
            r_radial             <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW0_LO:    r_xform[REG_ROW0_LO] <= i_cfg_data;
                REG_ROW0_HI:    r_xform[REG_ROW0_HI] <= i_cfg_data;
                REG_ROW1_LO:    r_xform[REG_ROW1_LO] <= i_cfg_data;
                REG_ROW1_HI:    r_xform[REG_ROW1_HI] <= i_cfg_data;
                REG_ROW2_LO:    r_xform[REG_ROW2_LO] <= i_cfg_data;
                REG_ROW2_HI:    r_xform[REG_ROW2_HI] <= i_cfg_data;
                REG_INTRINSICS: r_intr               <= i_cfg_data;
                REG_RADIAL:     r_radial             <= i_cfg_data[62:0];
                default: begin
                end
            endcase
        end
    end

    cpp_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_xform   (r_xform),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_valid   (x_vld),
        .o_cam_x   (cam_x),
        .o_cam_y   (cam_y),
        .o_cam_z   (cam_z),
        .o_invalid (x_inv),
        .o_depth   (x_dep)
    );

    cpp_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (x_vld),
        .i_cam_x   (cam_x),
        .i_cam_y   (cam_y),
        .i_cam_z   (cam_z),
        .i_invalid (x_inv),
        .i_depth   (x_dep),
        .o_valid   (n_vld),
        .o_norm_x  (norm_x),
        .o_norm_y  (norm_y),
        .o_invalid (n_inv),
        .o_depth   (n_dep)
    );

    cpp_distort u_distort (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (n_vld),
        .i_intrinsics (r_intr),
        .i_radial     (r_radial),
        .i_norm_x     (norm_x),
        .i_norm_y     (norm_y),
        .i_invalid    (n_inv),
        .i_depth      (n_dep),
        .o_valid      (o_out_valid),
        .o_pixel_u    (o_pixel_u),
        .o_pixel_v    (o_pixel_v),
        .o_invalid    (o_depth_invalid),
        .o_depth      (o_cam_depth)
    );

    // An invalid depth gives a zero pixel
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_invalid |-> (o_pixel_u == 0) && (o_pixel_v == 0))
        else $error("pixel not zero for invalid depth");

    // A valid depth is strictly positive
    a_depth_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_depth_invalid |-> !o_cam_depth[31] && (o_cam_depth != 0))
        else $error("depth flag disagrees with depth");

    // A stalled result is not replaced
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_u)
            && $stable(o_cam_depth))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/cpp_xform.sv =====
// ----------------------------------------------------------------------------
// cpp_xform
// Two-stage extrinsic transform: nine products, then exact row sums with
// translation. Flags non-positive depth.
// ----------------------------------------------------------------------------
module cpp_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  cpp_pkg::t_xform     i_xform,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    output logic                o_valid,
    output logic signed [50:0]  o_cam_x,
    output logic signed [50:0]  o_cam_y,
    output logic signed [50:0]  o_cam_z,
    output logic                o_invalid,
    output logic signed [31:0]  o_depth
);
    import cpp_pkg::*;

    logic signed [63:0] r_prod [3][3];
    logic signed [63:0] n_prod [3][3];
    logic signed [50:0] r_cam  [3];
    logic signed [50:0] n_cam  [3];
    logic signed [65:0] sum    [3];
    logic signed [31:0] trans  [3];
    logic               r_vld1;
    logic               r_vld2;

    // Products of each matrix row with the point
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_prod[r][0] = $signed(i_xform[2*r][31:0])    * i_point_x;
            n_prod[r][1] = $signed(i_xform[2*r][63:32])   * i_point_y;
            n_prod[r][2] = $signed(i_xform[2*r+1][31:0])  * i_point_z;
            trans[r]     = $signed(i_xform[2*r+1][63:32]);
        end
    end

    // Floor of the Q32.32 sum to Q16.16, plus translation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = {{2{r_prod[r][0][63]}}, r_prod[r][0]}
                   + {{2{r_prod[r][1][63]}}, r_prod[r][1]}
                   + {{2{r_prod[r][2][63]}}, r_prod[r][2]};
            n_cam[r] = {sum[r][65], sum[r][65:16]} + {{19{trans[r][31]}}, trans[r]};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_cam  <= n_cam;
        end
    end

    assign o_valid   = r_vld2;
    assign o_cam_x   = r_cam[0];
    assign o_cam_y   = r_cam[1];
    assign o_cam_z   = r_cam[2];
    assign o_invalid = r_cam[2][50] || (r_cam[2] == '0);
    assign o_depth   = sat32({{16{r_cam[2][50]}}, r_cam[2]});

endmodule

// ===== rtl/core/cpp_norm.sv =====
// ----------------------------------------------------------------------------
// cpp_norm
// Normalizes x and y by depth: a setup stage, a restoring divider with one
// quotient bit per stage for both lanes, and a sign and saturation stage.
// ----------------------------------------------------------------------------
module cpp_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [50:0]  i_cam_x,
    input  logic signed [50:0]  i_cam_y,
    input  logic signed [50:0]  i_cam_z,
    input  logic                i_invalid,
    input  logic signed [31:0]  i_depth,
    output logic                o_valid,
    output logic signed [31:0]  o_norm_x,
    output logic signed [31:0]  o_norm_y,
    output logic                o_invalid,
    output logic signed [31:0]  o_depth
);
    import cpp_pkg::*;

    logic [49:0]        r_rem [2][QBITS+1];
    logic [49:0]        n_rem [2][QBITS+1];
    logic [31:0]        r_num [2][QBITS+1];
    logic [31:0]        n_num [2][QBITS+1];
    logic [31:0]        r_quo [2][QBITS+1];
    logic [31:0]        n_quo [2][QBITS+1];
    logic               r_neg [2][QBITS+1];
    logic               n_neg [2];
    logic               r_ovf [2][QBITS+1];
    logic               n_ovf [2];
    logic [49:0]        r_den [QBITS+1];
    logic               r_inv [QBITS+1];
    logic signed [31:0] r_dep [QBITS+1];
    logic               r_vld [QBITS+1];
    logic signed [50:0] num_in [2];
    logic signed [47:0] clamp [2];
    logic [47:0]        mag [2];
    logic [50:0]        trial [2][QBITS];
    logic [51:0]        diff [2][QBITS];
    logic signed [31:0] r_res [2];
    logic signed [31:0] n_res [2];
    logic               r_out_inv;
    logic signed [31:0] r_out_dep;
    logic               r_out_vld;

    assign num_in[0] = i_cam_x;
    assign num_in[1] = i_cam_y;

    // Setup and divider steps for both lanes
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // clamp to Q32.16, split sign, check for quotient overflow
            if (num_in[l][50] && !(&num_in[l][49:47])) begin
                clamp[l] = 48'sh8000_0000_0000;
            end else if (!num_in[l][50] && (|num_in[l][49:47])) begin
                clamp[l] = 48'sh7FFF_FFFF_FFFF;
            end else begin
                clamp[l] = num_in[l][47:0];
            end
            n_neg[l]    = clamp[l][47];
            mag[l]      = n_neg[l] ? (~clamp[l] + 48'd1) : clamp[l];
            n_ovf[l]    = {18'd0, mag[l]} >= {i_cam_z[49:0], 16'd0};
            n_rem[l][0] = {18'd0, mag[l][47:16]};
            n_num[l][0] = {mag[l][15:0], 16'd0};
            n_quo[l][0] = '0;
            // shift in one dividend bit, subtract where it fits
            for (int k = 0; k < QBITS; k++) begin
                trial[l][k]   = {r_rem[l][k], r_num[l][k][31]};
                diff[l][k]    = {1'b0, trial[l][k]} - {2'b00, r_den[k]};
                n_num[l][k+1] = {r_num[l][k][30:0], 1'b0};
                if (!diff[l][k][51]) begin
                    n_rem[l][k+1] = diff[l][k][49:0];
                    n_quo[l][k+1] = {r_quo[l][k][30:0], 1'b1};
                end else begin
                    n_rem[l][k+1] = trial[l][k][49:0];
                    n_quo[l][k+1] = {r_quo[l][k][30:0], 1'b0};
                end
            end
        end
    end

    // Apply sign and saturate the quotient
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[l][QBITS]) begin
                if (r_ovf[l][QBITS] || (r_quo[l][QBITS] > 32'h8000_0000)) begin
                    n_res[l] = 32'sh8000_0000;
                end else begin
                    n_res[l] = $signed(32'd0 - r_quo[l][QBITS]);
                end
            end else begin
                if (r_ovf[l][QBITS] || r_quo[l][QBITS][31]) begin
                    n_res[l] = 32'sh7FFF_FFFF;
                end else begin
                    n_res[l] = $signed(r_quo[l][QBITS]);
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QBITS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < QBITS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_out_vld <= r_vld[QBITS];
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_neg[l][0] <= n_neg[l];
                r_ovf[l][0] <= n_ovf[l];
                for (int k = 0; k <= QBITS; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_num[l][k] <= n_num[l][k];
                    r_quo[l][k] <= n_quo[l][k];
                end
                for (int k = 0; k < QBITS; k++) begin
                    r_neg[l][k+1] <= r_neg[l][k];
                    r_ovf[l][k+1] <= r_ovf[l][k];
                end
            end
            r_den[0] <= i_cam_z[49:0];
            r_inv[0] <= i_invalid;
            r_dep[0] <= i_depth;
            for (int k = 0; k < QBITS; k++) begin
                r_den[k+1] <= r_den[k];
                r_inv[k+1] <= r_inv[k];
                r_dep[k+1] <= r_dep[k];
            end
            r_res     <= n_res;
            r_out_inv <= r_inv[QBITS];
            r_out_dep <= r_dep[QBITS];
        end
    end

    assign o_valid   = r_out_vld;
    assign o_norm_x  = r_res[0];
    assign o_norm_y  = r_res[1];
    assign o_invalid = r_out_inv;
    assign o_depth   = r_out_dep;

endmodule

// ===== rtl/core/cpp_distort.sv =====
// ----------------------------------------------------------------------------
// cpp_distort
// Radial distortion and intrinsics: r2, r4, r6, the polynomial factor,
// scaling of the normalized point, then focal scale and principal offset.
// ----------------------------------------------------------------------------
module cpp_distort (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_intrinsics,
    input  logic [62:0]         i_radial,
    input  logic signed [31:0]  i_norm_x,
    input  logic signed [31:0]  i_norm_y,
    input  logic                i_invalid,
    input  logic signed [31:0]  i_depth,
    output logic                o_valid,
    output logic signed [31:0]  o_pixel_u,
    output logic signed [31:0]  o_pixel_v,
    output logic                o_invalid,
    output logic signed [31:0]  o_depth
);
    import cpp_pkg::*;

    localparam int NSTG = 8;

    logic               r_vld [1:NSTG];
    logic               r_inv [1:NSTG];
    logic signed [31:0] r_dep [1:NSTG];
    logic signed [31:0] r_nx  [1:6];
    logic signed [31:0] r_ny  [1:6];
    logic [63:0]        r_sqx;
    logic [63:0]        r_sqy;
    logic [63:0]        sq_sum;
    logic [31:0]        r_r2  [2:4];
    logic [31:0]        r_r4  [3:4];
    logic [31:0]        r_r6;
    logic [63:0]        p_r4;
    logic [63:0]        p_r6;
    logic signed [53:0] r_kp  [3];
    logic signed [56:0] acc;
    logic signed [31:0] r_factor;
    logic signed [63:0] p_dx;
    logic signed [63:0] p_dy;
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic signed [48:0] p_fu;
    logic signed [48:0] p_fv;
    logic signed [50:0] sum_u;
    logic signed [50:0] sum_v;
    logic signed [31:0] r_u;
    logic signed [31:0] r_v;
    logic signed [20:0] k1;
    logic signed [20:0] k2;
    logic signed [20:0] k3;

    assign k1 = i_radial[20:0];
    assign k2 = i_radial[41:21];
    assign k3 = i_radial[62:42];

    // Radius powers
    assign sq_sum = r_sqx + r_sqy;
    assign p_r4   = r_r2[2] * r_r2[2];
    assign p_r6   = r_r4[3] * r_r2[3];

    // Polynomial factor
    assign acc = 57'sd4294967296
               + {{3{r_kp[0][53]}}, r_kp[0]}
               + {{3{r_kp[1][53]}}, r_kp[1]}
               + {{3{r_kp[2][53]}}, r_kp[2]};

    // Distorted normalized point
    assign p_dx = r_nx[6] * r_factor;
    assign p_dy = r_ny[6] * r_factor;

    // Focal scale and principal point
    assign p_fu  = r_dx * $signed({1'b0, i_intrinsics[15:0]});
    assign p_fv  = r_dy * $signed({1'b0, i_intrinsics[31:16]});
    assign sum_u = {{6{p_fu[48]}}, p_fu[48:4]} + {23'd0, i_intrinsics[47:32], 12'd0};
    assign sum_v = {{6{p_fv[48]}}, p_fv[48:4]} + {23'd0, i_intrinsics[63:48], 12'd0};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // carry the sideband fields
            r_inv[1] <= i_invalid;
            r_dep[1] <= i_depth;
            for (int k = 2; k <= NSTG; k++) begin
                r_inv[k] <= r_inv[k-1];
                r_dep[k] <= r_dep[k-1];
            end
            r_nx[1] <= i_norm_x;
            r_ny[1] <= i_norm_y;
            for (int k = 2; k <= 6; k++) begin
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
            end
            // squares, r2, r4, r6
            r_sqx   <= 64'(i_norm_x * i_norm_x);
            r_sqy   <= 64'(i_norm_y * i_norm_y);
            r_r2[2] <= usat_q16(sq_sum);
            r_r2[3] <= r_r2[2];
            r_r2[4] <= r_r2[3];
            r_r4[3] <= usat_q16(p_r4);
            r_r4[4] <= r_r4[3];
            r_r6    <= usat_q16(p_r6);
            // coefficient products, then factor
            r_kp[0] <= k1 * $signed({1'b0, r_r2[4]});
            r_kp[1] <= k2 * $signed({1'b0, r_r4[4]});
            r_kp[2] <= k3 * $signed({1'b0, r_r6});
            r_factor <= sat32({{26{acc[56]}}, acc[56:16]});
            r_dx <= sat32({{19{p_dx[63]}}, p_dx[63:16]});
            r_dy <= sat32({{19{p_dy[63]}}, p_dy[63:16]});
            r_u  <= r_inv[7] ? 32'sd0 : sat32({{16{sum_u[50]}}, sum_u});
            r_v  <= r_inv[7] ? 32'sd0 : sat32({{16{sum_v[50]}}, sum_v});
        end
    end

    assign o_valid   = r_vld[NSTG];
    assign o_pixel_u = r_u;
    assign o_pixel_v = r_v;
    assign o_invalid = r_inv[NSTG];
    assign o_depth   = r_dep[NSTG];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for camera_point_projection. A queue-fed driver pushes
// world points over the valid/ready input, a scoreboard predicts pixel u/v,
// camera depth and the invalid-depth flag for every transfer, and a monitor
// compares each output transfer in order. Configuration changes only while
// the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import cpp_pkg::*;

    localparam logic [3:0] REG_NONE   = 4'd11;   // index past the register map
    localparam int         DRAIN_CYC  = 60;      // pipeline latency plus margin
    localparam int         CYC_LIMIT  = 400000;

    typedef enum int {SETUP_TYPICAL, SETUP_RANDOM, SETUP_MAX, SETUP_MIN} t_setup;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] depth;
        logic               invalid;
    } t_pixel;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [3:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_pixel_u;
    logic signed [31:0] o_pixel_v;
    logic signed [31:0] o_cam_depth;
    logic               o_depth_invalid;

    camera_point_projection uut (.*);

    // Shadow copy of the register file
    logic [63:0] shadow_regs [8];

    t_point  point_queue[$];
    t_pixel  pixel_queue[$];
    logic    point_taken;
    logic    no_idle;
    int      mismatches;
    int      points_sent;
    int      pixels_seen;
    int      invalid_seen;
    int      cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Exact floor of the Q32.32 row sum back to Q16.16, plus translation
    function automatic longint row_sum(int r, longint px, longint py, longint pz);
        longint p0, p1, p2, hsum;
        logic [63:0] lsum;
        p0 = longint'($signed(shadow_regs[2*r][31:0])) * px;
        p1 = longint'($signed(shadow_regs[2*r][63:32])) * py;
        p2 = longint'($signed(shadow_regs[2*r+1][31:0])) * pz;
        hsum = (p0 >>> 16) + (p1 >>> 16) + (p2 >>> 16);
        lsum = 64'(p0[15:0]) + 64'(p1[15:0]) + 64'(p2[15:0]);
        return hsum + longint'(lsum >> 16) + longint'($signed(shadow_regs[2*r+1][63:32]));
    endfunction

    // Q16.16 quotient, truncated toward zero, saturated to 32 bits
    function automatic longint divide_depth(longint num, longint den);
        longint n;
        logic [63:0] mag, q;
        n = num;
        if (n > (64'sd1 <<< 47) - 1) n = (64'sd1 <<< 47) - 1;
        if (n < -(64'sd1 <<< 47)) n = -(64'sd1 <<< 47);
        mag = (n < 0) ? 64'(-n) : 64'(n);
        q = (mag << 16) / 64'(den);
        if (n < 0) return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic logic [63:0] sat_u32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic longint scale_offset(longint n, longint factor, longint f, longint c);
        longint d;
        d = clip32((n * factor) >>> 16);
        return clip32(((d * f) >>> 4) + (c <<< 12));
    endfunction

    function automatic t_pixel project_point(t_point p);
        t_pixel res;
        longint cx, cy, cz, xn, yn, k1, k2, k3, acc, factor;
        logic [63:0] sq, r2, r4, r6, intr, rc;
        cx = row_sum(0, p.x, p.y, p.z);
        cy = row_sum(1, p.x, p.y, p.z);
        cz = row_sum(2, p.x, p.y, p.z);
        res.depth = 32'(clip32(cz));
        res.invalid = (cz <= 0);
        res.u = '0;
        res.v = '0;
        if (!res.invalid) begin
            intr = shadow_regs[REG_INTRINSICS];
            rc = shadow_regs[REG_RADIAL];
            xn = divide_depth(cx, cz);
            yn = divide_depth(cy, cz);
            sq = 64'(xn * xn) + 64'(yn * yn);
            r2 = sat_u32(sq >> 16);
            r4 = sat_u32((r2 * r2) >> 16);
            r6 = sat_u32((r4 * r2) >> 16);
            k1 = longint'($signed(rc[20:0]));
            k2 = longint'($signed(rc[41:21]));
            k3 = longint'($signed(rc[62:42]));
            acc = (64'sd1 <<< 32) + k1 * longint'(r2) + k2 * longint'(r4)
                + k3 * longint'(r6);
            factor = clip32(acc >>> 16);
            res.u = 32'(scale_offset(xn, factor, longint'(intr[15:0]),
                                     longint'(intr[47:32])));
            res.v = 32'(scale_offset(yn, factor, longint'(intr[31:16]),
                                     longint'(intr[63:48])));
        end
        return res;
    endfunction

    // Drive inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || point_taken) begin
                if (point_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 31)) begin
                    i_in_valid <= 1'b1;
                    i_point_x  <= point_queue[0].x;
                    i_point_y  <= point_queue[0].y;
                    i_point_z  <= point_queue[0].z;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    // Sample both channels on the rising edge
    always @(posedge i_clk) begin
        t_pixel exp_px;
        t_point in_pt;
        cycles <= cycles + 1;
        point_taken = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            in_pt = point_queue.pop_front();
            pixel_queue.insert(pixel_queue.size(), project_point(in_pt));
            point_taken = 1'b1;
            points_sent++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transfer: u=%0d v=%0d depth=%0d inv=%0b",
                             o_pixel_u, o_pixel_v, o_cam_depth, o_depth_invalid);
            end else begin
                exp_px = pixel_queue.pop_front();
                if (exp_px.invalid) invalid_seen++;
                if (o_pixel_u !== exp_px.u || o_pixel_v !== exp_px.v ||
                    o_cam_depth !== exp_px.depth || o_depth_invalid !== exp_px.invalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp u=%0d v=%0d d=%0d inv=%0b got u=%0d v=%0d d=%0d inv=%0b",
                                 exp_px.u, exp_px.v, exp_px.depth, exp_px.invalid,
                                 o_pixel_u, o_pixel_v, o_cam_depth, o_depth_invalid);
                end
            end
        end
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx < 8) shadow_regs[idx] = (idx == REG_RADIAL) ? {1'b0, data[62:0]} : data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coef(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [20:0] rand_k();
        return 21'($signed($urandom_range(0, 65536)) - 32768);
    endfunction

    task automatic load_setup(t_setup s);
        logic [63:0] row_val;
        for (int i = 0; i < 6; i++) begin
            case (s)
                SETUP_TYPICAL: begin
                    row_val = {rand_coef(65536), rand_coef(81920)};
                    // keep the diagonal dominant and push depth forward
                    if (i == 0) row_val[31:0] = 32'h0001_0000 + rand_coef(8192);
                    if (i == 2) row_val[63:32] = 32'h0001_0000 + rand_coef(8192);
                    if (i == 5) row_val = {32'h0008_0000 + rand_coef(262144),
                                           32'h0001_0000 + rand_coef(8192)};
                end
                SETUP_RANDOM: row_val = {$urandom, $urandom};
                SETUP_MAX:    row_val = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
                default:      row_val = {32'h8000_0000, 32'h8000_0000};
            endcase
            write_reg(REG_ROW0_LO + 4'(i), row_val);
        end
        case (s)
            SETUP_TYPICAL: begin
                write_reg(REG_INTRINSICS, {16'($urandom_range(0, 7680)),
                                           16'($urandom_range(0, 10240)),
                                           16'($urandom_range(3200, 16000)),
                                           16'($urandom_range(3200, 16000))});
                write_reg(REG_RADIAL, {1'b0, rand_k(), rand_k(), rand_k()});
            end
            SETUP_RANDOM: begin
                write_reg(REG_INTRINSICS, {$urandom, $urandom});
                write_reg(REG_RADIAL, {$urandom, $urandom});
            end
            SETUP_MAX: begin
                write_reg(REG_INTRINSICS, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_RADIAL, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
            end
            default: begin
                write_reg(REG_INTRINSICS, 64'h0);
                write_reg(REG_RADIAL, {1'b1, 21'h100000, 21'h100000, 21'h100000});
            end
        endcase
        // writes past the map must be dropped
        write_reg(REG_NONE, {$urandom, $urandom});
    endtask

    task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        point_queue.insert(point_queue.size(), p);
    endtask

    // Mostly points in front of the camera, some wild ones
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0)
                queue_point(rand_coef(8 << 16), rand_coef(8 << 16),
                            32'($urandom_range(1 << 12, 64 << 16)));
            else
                queue_point($urandom, $urandom, $urandom);
        end
    endtask

    // Let every transfer come back, then let the pipe settle
    task automatic drain();
        while (point_queue.size() > 0 || pixel_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_point_x   = '0;
        i_point_y   = '0;
        i_point_z   = '0;
        point_taken = 1'b0;
        no_idle     = 1'b0;
        mismatches  = 0;
        points_sent = 0;
        pixels_seen = 0;
        invalid_seen = 0;
        cycles      = 0;
        shadow_regs[0] = RST_ROW0_LO;
        shadow_regs[1] = '0;
        shadow_regs[2] = RST_ROW1_LO;
        shadow_regs[3] = '0;
        shadow_regs[4] = '0;
        shadow_regs[5] = RST_ROW2_HI;
        shadow_regs[6] = '0;
        shadow_regs[7] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset setup: identity transform, zero intrinsics
        queue_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_point(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
        drain();

        // Directed points with a plausible camera
        write_reg(REG_ROW0_LO, RST_ROW0_LO);
        write_reg(REG_ROW1_LO, RST_ROW1_LO);
        write_reg(REG_ROW2_LO, 64'h0);
        write_reg(REG_ROW0_HI, 64'h0);
        write_reg(REG_ROW1_HI, 64'h0);
        write_reg(REG_ROW2_HI, RST_ROW2_HI);
        write_reg(REG_INTRINSICS, {16'd3840, 16'd5120, 16'd8000, 16'd8000});
        write_reg(REG_RADIAL, {1'b0, 21'h001000, 21'h1FF000, 21'h004000});
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        queue_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);   // near-zero depth
        queue_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);   // zero depth
        queue_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);   // negative depth
        queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_point(32'h0010_0000, 32'h0000_8000, 32'h0000_1000);   // huge normalized coords
        drain();

        // Half-scale depth: a one-step z floors to zero depth
        write_reg(REG_ROW2_HI, 64'h0000_0000_0000_8000);
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0002);
        queue_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0003);
        drain();

        // Extreme register settings
        load_setup(SETUP_MAX);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_random(60);
        drain();
        load_setup(SETUP_MIN);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_point(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_random(60);
        drain();

        // Random phases over many setups, one without any idling
        for (int ph = 0; ph < 8; ph++) begin
            load_setup((ph % 4 == 3) ? SETUP_RANDOM : SETUP_TYPICAL);
            no_idle = (ph == 2);
            queue_random(176);
            drain();
        end
        no_idle = 1'b0;

        $display("projected %0d points, %0d results checked, %0d with invalid depth",
                 points_sent, pixels_seen, invalid_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/cpp_pkg.sv
rtl/core/cpp_xform.sv
rtl/core/cpp_norm.sv
rtl/core/cpp_distort.sv
rtl/core/camera_point_projection.sv
sim/tb_top.sv
